### hw/rtl/tesl_pkg.sv
// ----------------------------------------------------------------------------
// Timed event slot table package
// Shared opcodes, command classes, status codes and command record.
// ----------------------------------------------------------------------------
package tesl_pkg;

	localparam int unsigned SLOTS_DEF   = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_ADD_PERIODIC = 3'd0,
		OP_ADD_ONESHOT  = 3'd1,
		OP_REMOVE       = 3'd2,
		OP_LENGTHEN     = 3'd3,
		OP_TICK         = 3'd4,
		OP_RUN          = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		CL_NOP,
		CL_ADD,
		CL_REMOVE,
		CL_LENGTHEN,
		CL_TICK,
		CL_RUN
	} cls_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	localparam logic [1:0] KIND_EMPTY = 2'd0;

	localparam logic signed [15:0] PERIODIC_MARK = -16'sd1;

	typedef struct packed {
		cls_t               cls;
		logic [7:0]         event_id;
		logic [15:0]        event_arg;
		logic [1:0]         kind;
		logic signed [15:0] delay;
		logic signed [15:0] init_count;
	} cmd_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_SCAN,
		BS_DONE
	} bstate_t;

endpackage

### hw/rtl/tesl_if.sv
// ----------------------------------------------------------------------------
// Timed event slot table channels
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface tesl_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [7:0]         event_id;
	logic [15:0]        event_arg;
	logic [1:0]         kind;
	logic signed [15:0] delay;

	modport source (output valid, opcode, event_id, event_arg, kind, delay, input ready);
	modport sink   (input valid, opcode, event_id, event_arg, kind, delay, output ready);
endinterface

interface tesl_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        fired;
	logic [7:0]  fired_id;
	logic [15:0] fired_arg;
	logic        last;

	modport source (output valid, status, fired, fired_id, fired_arg, last, input ready);
	modport sink   (input valid, status, fired, fired_id, fired_arg, last, output ready);
endinterface

### hw/rtl/tesl_front.sv
// ----------------------------------------------------------------------------
// Timed event slot table front end
// Accepts commands, decodes the opcode into a command class and pushes
// the decoded command into the queue.
// ----------------------------------------------------------------------------
module tesl_front (
	tesl_cmd_if.sink         cmd,
	input  logic             q_full,
	output logic             push,
	output tesl_pkg::cmd_t   push_data
);

	assign cmd.ready = !q_full;
	assign push      = cmd.valid && !q_full;

	always_comb begin
		push_data.event_id   = cmd.event_id;
		push_data.event_arg  = cmd.event_arg;
		push_data.kind       = cmd.kind;
		push_data.delay      = cmd.delay;
		push_data.init_count = cmd.delay;
		case (cmd.opcode)
			tesl_pkg::OP_ADD_PERIODIC: begin
				push_data.cls        = tesl_pkg::CL_ADD;
				push_data.init_count = tesl_pkg::PERIODIC_MARK;
			end
			tesl_pkg::OP_ADD_ONESHOT: begin
				push_data.cls = tesl_pkg::CL_ADD;
			end
			tesl_pkg::OP_REMOVE: begin
				push_data.cls = tesl_pkg::CL_REMOVE;
			end
			tesl_pkg::OP_LENGTHEN: begin
				push_data.cls = tesl_pkg::CL_LENGTHEN;
			end
			tesl_pkg::OP_TICK: begin
				// an empty class is decoded as a no-op, so nothing can fire
				push_data.cls = (cmd.kind == tesl_pkg::KIND_EMPTY) ?
					tesl_pkg::CL_NOP : tesl_pkg::CL_TICK;
			end
			tesl_pkg::OP_RUN: begin
				push_data.cls = (cmd.kind == tesl_pkg::KIND_EMPTY) ?
					tesl_pkg::CL_NOP : tesl_pkg::CL_RUN;
			end
			default: begin
				push_data.cls = tesl_pkg::CL_NOP;
			end
		endcase
	end

endmodule

### hw/rtl/tesl_queue.sv
// ----------------------------------------------------------------------------
// Timed event slot table command queue
// Short FIFO of decoded commands between the front end and the scanner.
// ----------------------------------------------------------------------------
module tesl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tesl_pkg::cmd_t   push_data,
	output logic             full,
	output logic             q_valid,
	output tesl_pkg::cmd_t   q_data,
	input  logic             q_pop
);

	localparam int unsigned DEPTH = tesl_pkg::QUEUE_DEPTH;
	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	tesl_pkg::cmd_t  entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_data  = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/tesl_back.sv
// ----------------------------------------------------------------------------
// Timed event slot table scanner
// Pops one command, walks the slot table one slot a cycle unless held for a
// busy output, and reports status and fired events through a result register.
// ----------------------------------------------------------------------------
module tesl_back #(
	parameter int unsigned SLOTS = tesl_pkg::SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  tesl_pkg::cmd_t   q_data,
	output logic             q_pop,
	tesl_res_if.source       res
);

	localparam int unsigned IDXW = $clog2(SLOTS);

	typedef struct packed {
		logic [7:0]         id;
		logic [15:0]        arg;
		logic signed [15:0] count;
	} entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        fired;
		logic [7:0]  fired_id;
		logic [15:0] fired_arg;
		logic        last;
	} result_t;

	entry_t              mem [SLOTS];
	logic [1:0]          kind_q [SLOTS];

	tesl_pkg::bstate_t   state_q, state_d;
	tesl_pkg::cmd_t      cmd_q;
	logic [IDXW:0]       iss_q;
	logic                s2_valid_q;
	logic [IDXW-1:0]     idx_s2;
	entry_t              rd_s2;
	logic                pend_valid_q;
	logic [7:0]          pend_id_q;
	logic [15:0]         pend_arg_q;
	logic [1:0]          status_q;
	logic                out_valid_q;
	result_t             out_q;

	logic                start;
	logic                eval;
	logic                out_free;
	logic                stall;
	logic                adv;
	logic                step;
	logic                scan_end;
	logic                iss_live;
	logic [1:0]          kind_cur;
	logic                hit;
	logic                fire;
	logic                mem_we;
	entry_t              mem_wdata;
	logic                kind_we;
	logic [1:0]          kind_wdata;
	logic signed [16:0]  sum;
	logic                load_scan;
	logic                load_done;
	result_t             out_d;

	assign eval     = (state_q == tesl_pkg::BS_SCAN) && s2_valid_q;
	assign out_free = !out_valid_q || res.ready;
	assign kind_cur = kind_q[idx_s2];
	assign sum      = {rd_s2.count[15], rd_s2.count} + {cmd_q.delay[15], cmd_q.delay};
	assign iss_live = (iss_q < (IDXW + 1)'(SLOTS));

	// slot evaluation
	always_comb begin
		hit        = 1'b0;
		fire       = 1'b0;
		mem_we     = 1'b0;
		mem_wdata  = rd_s2;
		kind_we    = 1'b0;
		kind_wdata = kind_cur;
		case (cmd_q.cls)
			tesl_pkg::CL_ADD: begin
				if (kind_cur == tesl_pkg::KIND_EMPTY) begin
					hit = 1'b1;
					if (cmd_q.kind != tesl_pkg::KIND_EMPTY) begin
						kind_we         = 1'b1;
						kind_wdata      = cmd_q.kind;
						mem_we          = 1'b1;
						mem_wdata.id    = cmd_q.event_id;
						mem_wdata.arg   = cmd_q.event_arg;
						mem_wdata.count = cmd_q.init_count;
					end
				end
			end
			tesl_pkg::CL_REMOVE: begin
				if (kind_cur != tesl_pkg::KIND_EMPTY && rd_s2.id == cmd_q.event_id) begin
					hit        = 1'b1;
					kind_we    = 1'b1;
					kind_wdata = tesl_pkg::KIND_EMPTY;
				end
			end
			tesl_pkg::CL_LENGTHEN: begin
				if (kind_cur != tesl_pkg::KIND_EMPTY && rd_s2.id == cmd_q.event_id) begin
					hit    = 1'b1;
					mem_we = 1'b1;
					// saturate on signed overflow
					if (sum[16] != sum[15]) begin
						mem_wdata.count = sum[16] ? 16'sh8000 : 16'sh7FFF;
					end else begin
						mem_wdata.count = sum[15:0];
					end
				end
			end
			tesl_pkg::CL_TICK: begin
				if (kind_cur == cmd_q.kind && rd_s2.count > 16'sd0) begin
					mem_we          = 1'b1;
					mem_wdata.count = rd_s2.count - 16'sd1;
					if (rd_s2.count == 16'sd1) begin
						fire       = 1'b1;
						kind_we    = 1'b1;
						kind_wdata = tesl_pkg::KIND_EMPTY;
					end
				end
			end
			tesl_pkg::CL_RUN: begin
				if (kind_cur == cmd_q.kind && rd_s2.count == tesl_pkg::PERIODIC_MARK) begin
					fire = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// a second event needs the held one moved out first
	assign stall     = eval && fire && pend_valid_q && !out_free;
	assign adv       = (state_q == tesl_pkg::BS_SCAN) && !stall;
	assign step      = eval && !stall;
	assign scan_end  = step && (hit || idx_s2 == IDXW'(SLOTS - 1));
	assign load_scan = step && fire && pend_valid_q;
	assign load_done = (state_q == tesl_pkg::BS_DONE) && out_free;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		start   = 1'b0;
		case (state_q)
			tesl_pkg::BS_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					start   = 1'b1;
					state_d = (q_data.cls == tesl_pkg::CL_NOP) ?
						tesl_pkg::BS_DONE : tesl_pkg::BS_SCAN;
				end
			end
			tesl_pkg::BS_SCAN: begin
				if (scan_end) begin
					state_d = tesl_pkg::BS_DONE;
				end
			end
			tesl_pkg::BS_DONE: begin
				if (out_free) begin
					state_d = tesl_pkg::BS_IDLE;
				end
			end
			default: begin
				state_d = tesl_pkg::BS_IDLE;
			end
		endcase
	end

	always_comb begin
		out_d.status    = tesl_pkg::ST_OK;
		out_d.fired     = 1'b1;
		out_d.fired_id  = pend_id_q;
		out_d.fired_arg = pend_arg_q;
		out_d.last      = 1'b0;
		if (load_done) begin
			out_d.last = 1'b1;
			if (!pend_valid_q) begin
				out_d.status    = status_q;
				out_d.fired     = 1'b0;
				out_d.fired_id  = '0;
				out_d.fired_arg = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tesl_pkg::BS_IDLE;
			s2_valid_q   <= 1'b0;
			iss_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				kind_q[i] <= tesl_pkg::KIND_EMPTY;
			end
		end else begin
			state_q <= state_d;
			if (start) begin
				iss_q      <= '0;
				s2_valid_q <= 1'b0;
			end else if (adv) begin
				s2_valid_q <= iss_live;
				if (iss_live) begin
					iss_q <= iss_q + 1'b1;
				end
			end
			if (step && kind_we) begin
				kind_q[idx_s2] <= kind_wdata;
			end
			if (step && fire) begin
				pend_valid_q <= 1'b1;
			end else if (load_done) begin
				pend_valid_q <= 1'b0;
			end
			if (load_scan || load_done) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q    <= q_data;
			status_q <= tesl_pkg::ST_OK;
		end
		if (scan_end && !hit) begin
			case (cmd_q.cls)
				tesl_pkg::CL_ADD:      status_q <= tesl_pkg::ST_FULL;
				tesl_pkg::CL_REMOVE,
				tesl_pkg::CL_LENGTHEN: status_q <= tesl_pkg::ST_MISSING;
				default:               status_q <= tesl_pkg::ST_OK;
			endcase
		end
		if (step && fire) begin
			pend_id_q  <= rd_s2.id;
			pend_arg_q <= rd_s2.arg;
		end
		if (load_scan || load_done) begin
			out_q <= out_d;
		end
	end

	// slot table: write at the evaluated slot, read ahead at the issue index
	always_ff @(posedge clk) begin
		if (step && mem_we) begin
			mem[idx_s2] <= mem_wdata;
		end
		if (adv && iss_live) begin
			rd_s2  <= mem[iss_q[IDXW-1:0]];
			idx_s2 <= iss_q[IDXW-1:0];
		end
	end

	assign res.valid     = out_valid_q;
	assign res.status    = out_q.status;
	assign res.fired     = out_q.fired;
	assign res.fired_id  = out_q.fired_id;
	assign res.fired_arg = out_q.fired_arg;
	assign res.last      = out_q.last;

	a_add_only_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(step && kind_we && kind_wdata != tesl_pkg::KIND_EMPTY)
			|-> cmd_q.cls == tesl_pkg::CL_ADD)
		else $error("slot filled by a command other than add");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tesl_pkg::BS_IDLE) |-> !pend_valid_q)
		else $error("held event left over after command end");

	a_done_gives_last: assert property (@(posedge clk) disable iff (!arst_n)
		load_done |=> out_valid_q && res.last)
		else $error("command end did not present a final result");

	a_scan_starts_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tesl_pkg::BS_SCAN && $past(state_q) == tesl_pkg::BS_IDLE)
			|-> !s2_valid_q)
		else $error("scan started with stale slot data");

endmodule

### hw/rtl/timed_event_slot_table_core.sv
// ----------------------------------------------------------------------------
// Timed event slot table core
// Timer callout table: add, remove, lengthen, tick and run over a slot table,
// reporting fired events in slot order.
// ----------------------------------------------------------------------------
//  port  | dir | payload                                         | per transfer
//  cmd   | in  | opcode, event_id, event_arg, kind, delay        | one command
//  res   | out | status, fired, fired_id, fired_arg, last        | one result
//
//  Tick and run scan the whole table, one slot per cycle unless the scan is
//  held; add, remove and lengthen stop at the first match, while unused
//  opcodes and tick or run with the empty class do not scan at all.
//  Reset clears all slot kinds at once; no clearing pass, ready right away.
//  A stalled result port holds the scan only when a second event needs out.
//  The command queue keeps taking commands while the scanner is busy,
//  until its two entries are full.
// ----------------------------------------------------------------------------
module timed_event_slot_table_core #(
	parameter int unsigned SLOTS = tesl_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tesl_cmd_if.sink    cmd,
	tesl_res_if.source  res
);

	logic             push;
	tesl_pkg::cmd_t   push_data;
	logic             q_full;
	logic             q_valid;
	tesl_pkg::cmd_t   q_data;
	logic             q_pop;

	tesl_front u_front (
		.cmd       (cmd),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	tesl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop)
	);

	tesl_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

### dv/timed_event_slot_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event slot table core testbench
// Directed commands with known answers first, then random command mixes.
// Table fill bursts push the table to full and set up wide tick firings.
// Every result is checked field by field against a table model or a known row.
// ----------------------------------------------------------------------------
module timed_event_slot_table_core_test;
	import tesl_pkg::*;

	localparam int unsigned TABLE_SLOTS  = SLOTS_DEF;
	localparam int          RANDOM_ITEMS = 175;
	localparam int          TAIL_CYCLES  = 2 * TABLE_SLOTS + 8;
	localparam logic [2:0]  OP_SPARE6    = 3'd6;
	localparam logic [2:0]  OP_SPARE7    = 3'd7;

	typedef struct packed {
		logic [2:0]         op;
		logic [7:0]         id;
		logic [15:0]        arg;
		logic [1:0]         kind;
		logic signed [15:0] delay;
		logic               known;
		logic [1:0]         status;
	} command_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        fired;
		logic [7:0]  id;
		logic [15:0] arg;
		logic        last;
	} report_t;

	localparam int DIRECTED_ROWS = 25;

	// known rows carry a single result with fired low and the typed status
	command_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_TICK,         8'h00, 16'h0000, 2'd1,       16'sd0,      1'b1, ST_OK},
		'{OP_RUN,          8'h00, 16'h0000, 2'd3,       16'sd0,      1'b1, ST_OK},
		'{OP_REMOVE,       8'h55, 16'h0000, 2'd1,       16'sd0,      1'b1, ST_MISSING},
		'{OP_LENGTHEN,     8'hAA, 16'h0000, 2'd2,       16'sd5,      1'b1, ST_MISSING},
		'{OP_SPARE6,       8'h00, 16'h0000, KIND_EMPTY, 16'sd0,      1'b1, ST_OK},
		'{OP_SPARE7,       8'hFF, 16'hFFFF, 2'd3,       -16'sd1,     1'b1, ST_OK},
		'{OP_ADD_PERIODIC, 8'hFF, 16'hFFFF, 2'd3,       16'sd0,      1'b1, ST_OK},
		'{OP_ADD_ONESHOT,  8'h00, 16'h0000, 2'd1,       16'sd1,      1'b1, ST_OK},
		'{OP_ADD_ONESHOT,  8'h12, 16'h1234, 2'd1,       16'sd32767,  1'b1, ST_OK},
		'{OP_ADD_ONESHOT,  8'h34, 16'h8000, 2'd2,       -16'sd32768, 1'b1, ST_OK},
		'{OP_ADD_ONESHOT,  8'h56, 16'h5555, 2'd2,       16'sd0,      1'b1, ST_OK},
		'{OP_ADD_ONESHOT,  8'h78, 16'hAAAA, 2'd1,       -16'sd1,     1'b1, ST_OK},
		'{OP_ADD_PERIODIC, 8'h9A, 16'h7FFF, KIND_EMPTY, 16'sd0,      1'b1, ST_OK},
		'{OP_TICK,         8'h00, 16'h0000, 2'd1,       16'sd0,      1'b0, ST_OK},
		'{OP_RUN,          8'h00, 16'h0000, 2'd1,       16'sd0,      1'b0, ST_OK},
		'{OP_RUN,          8'h00, 16'h0000, 2'd3,       16'sd0,      1'b0, ST_OK},
		'{OP_TICK,         8'h00, 16'h0000, 2'd2,       16'sd0,      1'b0, ST_OK},
		'{OP_LENGTHEN,     8'h12, 16'h0000, 2'd1,       16'sd32767,  1'b1, ST_OK},
		'{OP_LENGTHEN,     8'h34, 16'h0000, 2'd1,       -16'sd32768, 1'b1, ST_OK},
		'{OP_LENGTHEN,     8'hFF, 16'h0000, 2'd1,       16'sd2,      1'b1, ST_OK},
		'{OP_TICK,         8'h00, 16'h0000, 2'd3,       16'sd0,      1'b0, ST_OK},
		'{OP_TICK,         8'h00, 16'h0000, KIND_EMPTY, 16'sd0,      1'b1, ST_OK},
		'{OP_RUN,          8'h00, 16'h0000, KIND_EMPTY, 16'sd0,      1'b1, ST_OK},
		'{OP_REMOVE,       8'h9A, 16'h0000, 2'd2,       16'sd0,      1'b1, ST_MISSING},
		'{OP_REMOVE,       8'h56, 16'h0000, 2'd2,       16'sd0,      1'b1, ST_OK}
	};

	logic clk;
	logic arst_n;

	tesl_cmd_if cmd_ch();
	tesl_res_if res_ch();

	timed_event_slot_table_core #(.SLOTS(TABLE_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// table copy kept by the testbench
	logic [1:0]         slot_class [TABLE_SLOTS];
	logic [7:0]         slot_event [TABLE_SLOTS];
	logic [15:0]        slot_param [TABLE_SLOTS];
	logic signed [15:0] slot_timer [TABLE_SLOTS];

	report_t step_reports[$];
	report_t due_reports[$];

	int send_idle_pct;
	int res_stall_pct;
	int commands_sent;
	int live_commands;
	int reports_checked;
	int fired_seen;
	int full_seen;
	int missing_seen;
	int errors;

	always #2 clk = ~clk;

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= res_stall_pct);
	end

	function automatic bit table_full();
		foreach (slot_class[i])
			if (slot_class[i] == KIND_EMPTY)
				return 1'b0;
		return 1'b1;
	endfunction

	// work out the results of one command and update the table copy
	function automatic void predict_reports(input command_t c);
		int      hit;
		int      total;
		logic [1:0] st;
		report_t rep;
		step_reports.delete();
		hit = -1;
		st = ST_OK;
		case (c.op)
		OP_ADD_PERIODIC, OP_ADD_ONESHOT: begin
			for (int i = TABLE_SLOTS - 1; i >= 0; i--)
				if (slot_class[i] == KIND_EMPTY)
					hit = i;
			if (hit < 0) begin
				st = ST_FULL;
			end else if (c.kind != KIND_EMPTY) begin
				slot_class[hit] = c.kind;
				slot_event[hit] = c.id;
				slot_param[hit] = c.arg;
				slot_timer[hit] = (c.op == OP_ADD_PERIODIC) ? PERIODIC_MARK : c.delay;
			end
		end
		OP_REMOVE, OP_LENGTHEN: begin
			for (int i = TABLE_SLOTS - 1; i >= 0; i--)
				if (slot_class[i] != KIND_EMPTY && slot_event[i] == c.id)
					hit = i;
			if (hit < 0) begin
				st = ST_MISSING;
			end else if (c.op == OP_REMOVE) begin
				slot_class[hit] = KIND_EMPTY;
			end else begin
				total = slot_timer[hit] + c.delay;
				if (total > 32767)
					total = 32767;
				if (total < -32768)
					total = -32768;
				slot_timer[hit] = 16'(total);
			end
		end
		OP_TICK, OP_RUN: begin
			if (c.kind != KIND_EMPTY) begin
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (slot_class[i] != c.kind)
						continue;
					rep = '{ST_OK, 1'b1, slot_event[i], slot_param[i], 1'b0};
					if (c.op == OP_TICK) begin
						if (slot_timer[i] > 16'sd0) begin
							slot_timer[i] = slot_timer[i] - 16'sd1;
							if (slot_timer[i] == 16'sd0) begin
								slot_class[i] = KIND_EMPTY;
								step_reports.push_back(rep);
							end
						end
					end else if (slot_timer[i] == PERIODIC_MARK) begin
						step_reports.push_back(rep);
					end
				end
			end
		end
		default: ;
		endcase
		if (step_reports.size() == 0)
			step_reports.push_back('{st, 1'b0, 8'h00, 16'h0000, 1'b0});
		step_reports[step_reports.size() - 1].last = 1'b1;
	endfunction

	function automatic logic signed [15:0] draw_delay();
		case ($urandom_range(0, 9))
		0, 1:    return 16'($urandom_range(0, 65535));
		2:       return -16'sd1;
		3:       return 16'sd0;
		default: return 16'($urandom_range(1, 5));
		endcase
	endfunction

	// ids from a short range collide often, which exercises first-match lookup
	function automatic logic [7:0] draw_id();
		logic [7:0] live[$];
		foreach (slot_class[i])
			if (slot_class[i] != KIND_EMPTY)
				live.push_back(slot_event[i]);
		if (live.size() != 0 && $urandom_range(0, 3) != 0)
			return live[$urandom_range(0, live.size() - 1)];
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic command_t fill_command();
		command_t c;
		c.op     = ($urandom_range(0, 4) == 0) ? OP_ADD_PERIODIC : OP_ADD_ONESHOT;
		c.id     = draw_id();
		c.arg    = 16'($urandom_range(0, 65535));
		c.kind   = 2'($urandom_range(1, 3));
		c.delay  = 16'($urandom_range(1, 3));
		c.known  = 1'b0;
		c.status = ST_OK;
		return c;
	endfunction

	function automatic command_t random_command();
		command_t c;
		int       pick;
		pick     = $urandom_range(0, 99);
		c.id     = draw_id();
		c.arg    = 16'($urandom_range(0, 65535));
		c.kind   = ($urandom_range(0, 19) == 0) ? KIND_EMPTY : 2'($urandom_range(1, 3));
		c.delay  = draw_delay();
		c.known  = 1'b0;
		c.status = ST_OK;
		if (pick < 28)
			c.op = OP_ADD_ONESHOT;
		else if (pick < 38)
			c.op = OP_ADD_PERIODIC;
		else if (pick < 48)
			c.op = OP_REMOVE;
		else if (pick < 58)
			c.op = OP_LENGTHEN;
		else if (pick < 88)
			c.op = OP_TICK;
		else if (pick < 97)
			c.op = OP_RUN;
		else
			c.op = $urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6;
		return c;
	endfunction

	// start and end at a falling edge; valid stays high into the next command
	task automatic issue_command(input command_t c);
		if (commands_sent < 80) begin
			send_idle_pct = 34;
			res_stall_pct = 74;
		end else if (commands_sent < 160) begin
			send_idle_pct = 74;
			res_stall_pct = 34;
		end else begin
			send_idle_pct = 0;
			res_stall_pct = 0;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.opcode    <= c.op;
		cmd_ch.event_id  <= c.id;
		cmd_ch.event_arg <= c.arg;
		cmd_ch.kind      <= c.kind;
		cmd_ch.delay     <= c.delay;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		predict_reports(c);
		if (c.known)
			due_reports.push_back('{c.status, 1'b0, 8'h00, 16'h0000, 1'b1});
		else
			foreach (step_reports[k])
				due_reports.push_back(step_reports[k]);
		commands_sent++;
		if (c.op <= OP_RUN)
			live_commands++;
		@(negedge clk);
	endtask

	task automatic check_report(input report_t want, input report_t got);
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.fired !== want.fired) begin
			$error("fired: expected %0d, got %0d", want.fired, got.fired);
			errors++;
		end
		if (got.id !== want.id) begin
			$error("fired_id: expected 0x%02h, got 0x%02h", want.id, got.id);
			errors++;
		end
		if (got.arg !== want.arg) begin
			$error("fired_arg: expected 0x%04h, got 0x%04h", want.arg, got.arg);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		report_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.status, res_ch.fired, res_ch.fired_id, res_ch.fired_arg,
				res_ch.last};
			if (due_reports.size() == 0) begin
				$error("result transfer with nothing expected: fired_id 0x%02h", got.id);
				errors++;
			end else begin
				check_report(due_reports.pop_front(), got);
			end
			reports_checked++;
			if (got.fired)
				fired_seen++;
			if (got.status == ST_FULL)
				full_seen++;
			if (got.status == ST_MISSING)
				missing_seen++;
		end
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.opcode    = OP_ADD_PERIODIC;
		cmd_ch.event_id  = 8'h00;
		cmd_ch.event_arg = 16'h0000;
		cmd_ch.kind      = KIND_EMPTY;
		cmd_ch.delay     = 16'sd0;
		res_ch.ready     = 1'b0;
		send_idle_pct    = 0;
		res_stall_pct    = 0;
		commands_sent    = 0;
		live_commands    = 0;
		reports_checked  = 0;
		fired_seen       = 0;
		full_seen        = 0;
		missing_seen     = 0;
		errors           = 0;
		foreach (slot_class[i]) begin
			slot_class[i] = KIND_EMPTY;
			slot_event[i] = 8'h00;
			slot_param[i] = 16'h0000;
			slot_timer[i] = 16'sd0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			issue_command(directed_rows[r]);

		while (live_commands < DIRECTED_ROWS + RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0
					&& live_commands < DIRECTED_ROWS + RANDOM_ITEMS - 40) begin
				// fill the table, then hit it twice more while full
				while (!table_full())
					issue_command(fill_command());
				repeat (2)
					issue_command(fill_command());
			end else begin
				issue_command(random_command());
			end
		end
		cmd_ch.valid <= 1'b0;

		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d commands and %0d result transfers, %0d fired events,",
			commands_sent, reports_checked, fired_seen);
		$display("with %0d table-full adds and %0d lookups that missed", full_seen,
			missing_seen);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
hw/rtl/tesl_pkg.sv
hw/rtl/tesl_if.sv
hw/rtl/tesl_front.sv
hw/rtl/tesl_queue.sv
hw/rtl/tesl_back.sv
hw/rtl/timed_event_slot_table_core.sv
dv/timed_event_slot_table_core_test.sv
